// ===== hw/rtl/mlpd_pkg.sv =====
// shared types and constants of the multi-level long-press detector
package mlpd_pkg;

	// field widths fixed by the interface
	localparam int DURATION_WIDTH = 16;
	localparam int LEVEL_WIDTH = 3;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int THRESHOLD_SLOTS = 6;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LEVEL = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_COUNT = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD_BASE = 3'd2;

	// item modes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// reset values of the registers
	localparam logic ACTIVE_LEVEL_RESET = 1'b0;
	localparam logic [LEVEL_WIDTH-1:0] LEVEL_COUNT_RESET = 3'd6;
	localparam logic [THRESHOLD_SLOTS-1:0][CFG_DATA_WIDTH-1:0] THRESHOLD_RESET = {
		16'd5000, 16'd4000, 16'd3000, 16'd2000, 16'd1000, 16'd500
	};

	typedef struct packed {
		logic mode;
		logic pin_level;
	} item_t;

	typedef struct packed {
		logic                      released;
		logic [DURATION_WIDTH-1:0] press_duration;
		logic [LEVEL_WIDTH-1:0]    press_level;
		logic                      max_reached;
		logic                      held;
	} result_t;

	// decoded configuration handed to the datapath
	typedef struct packed {
		logic                   active_level;
		logic [LEVEL_WIDTH-1:0] level_count;
	} cfg_t;

endpackage

// ===== hw/rtl/mlpd_cfg.sv =====
// configuration register file with level count clamping
module mlpd_cfg #(
	parameter int MAX_LEVELS = 6
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    cfg_valid,
	output logic                                                    cfg_ready,
	input  logic [mlpd_pkg::CFG_INDEX_WIDTH-1:0]                    cfg_index,
	input  logic [mlpd_pkg::CFG_DATA_WIDTH-1:0]                     cfg_data,
	output mlpd_pkg::cfg_t                                          cfg,
	output logic [MAX_LEVELS-1:0][mlpd_pkg::CFG_DATA_WIDTH-1:0]     thresholds
);

	logic                                  active_level_q;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0]      level_count_q;
	logic [MAX_LEVELS-1:0][mlpd_pkg::CFG_DATA_WIDTH-1:0] thresholds_q;
	logic                                  wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= mlpd_pkg::ACTIVE_LEVEL_RESET;
			level_count_q <= mlpd_pkg::LEVEL_COUNT_RESET;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				thresholds_q[i] <= mlpd_pkg::THRESHOLD_RESET[i];
			end
		end else if (wr) begin
			if (cfg_index == mlpd_pkg::CFG_ACTIVE_LEVEL) begin
				active_level_q <= cfg_data[0];
			end
			if (cfg_index == mlpd_pkg::CFG_LEVEL_COUNT) begin
				level_count_q <= cfg_data[mlpd_pkg::LEVEL_WIDTH-1:0];
			end
			// slots beyond the instantiated levels are dropped
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if (cfg_index ==
				    mlpd_pkg::CFG_THRESHOLD_BASE + mlpd_pkg::CFG_INDEX_WIDTH'(i)) begin
					thresholds_q[i] <= cfg_data;
				end
			end
		end
	end

	// zero counts as one, anything above the built levels as the top
	always_comb begin
		cfg.active_level = active_level_q;
		if (level_count_q == '0) begin
			cfg.level_count = mlpd_pkg::LEVEL_WIDTH'(1);
		end else if (level_count_q > mlpd_pkg::LEVEL_WIDTH'(MAX_LEVELS)) begin
			cfg.level_count = mlpd_pkg::LEVEL_WIDTH'(MAX_LEVELS);
		end else begin
			cfg.level_count = level_count_q;
		end
	end

	assign thresholds = thresholds_q;

endmodule

// ===== hw/rtl/mlpd_step.sv =====
// next-state and result logic for one item
module mlpd_step #(
	parameter int MAX_LEVELS = 6,
	parameter int TIME_WIDTH = 16
) (
	input  mlpd_pkg::item_t                                     item,
	input  mlpd_pkg::cfg_t                                      cfg,
	input  logic [MAX_LEVELS-1:0][mlpd_pkg::CFG_DATA_WIDTH-1:0] thresholds,
	input  logic                                                last_pin,
	input  logic                                                timing,
	input  logic [TIME_WIDTH-1:0]                               elapsed,
	input  logic [mlpd_pkg::LEVEL_WIDTH-1:0]                    level,
	input  logic [TIME_WIDTH-1:0]                               last_duration,
	input  logic                                                max_flag,
	output logic                                                last_pin_nx,
	output logic                                                timing_nx,
	output logic [TIME_WIDTH-1:0]                               elapsed_nx,
	output logic [mlpd_pkg::LEVEL_WIDTH-1:0]                    level_nx,
	output logic [TIME_WIDTH-1:0]                               last_duration_nx,
	output logic                                                max_flag_nx,
	output mlpd_pkg::result_t                                   result
);

	logic                             change;
	logic                             press_start;
	logic                             done;
	logic                             update;
	logic                             released;
	logic [TIME_WIDTH-1:0]            elapsed_inc;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0] cand;
	logic [31:0]                      dur_wide;

	always_comb begin
		change = item.pin_level != last_pin;
		press_start = change && (item.pin_level == cfg.active_level);
		done = 1'b0;
		released = 1'b0;
		last_pin_nx = last_pin;
		timing_nx = timing;
		level_nx = level;
		max_flag_nx = max_flag;
		last_duration_nx = last_duration;
		cand = '0;
		update = 1'b0;

		// timer runs on every tick of a press except the one that starts it
		if (timing && !press_start && (elapsed != {TIME_WIDTH{1'b1}})) begin
			elapsed_inc = elapsed + TIME_WIDTH'(1);
		end else begin
			elapsed_inc = elapsed;
		end
		elapsed_nx = elapsed_inc;

		if (item.mode == mlpd_pkg::MODE_CLEAR) begin
			last_duration_nx = '0;
			level_nx = '0;
			max_flag_nx = 1'b0;
			timing_nx = 1'b0;
			elapsed_nx = '0;
		end else begin
			if (change) begin
				last_pin_nx = item.pin_level;
				if (press_start) begin
					timing_nx = 1'b1;
					elapsed_nx = '0;
				end else if (timing) begin
					last_duration_nx = elapsed_inc;
					timing_nx = 1'b0;
					released = 1'b1;
					done = 1'b1;
				end
			end

			update = !done && timing_nx && (last_pin_nx == cfg.active_level);

			// highest level in use whose threshold the held time has met
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if ((mlpd_pkg::LEVEL_WIDTH'(i) < cfg.level_count) &&
				    (32'(elapsed_nx) >= 32'(thresholds[i]))) begin
					cand = mlpd_pkg::LEVEL_WIDTH'(i + 1);
				end
			end

			if (update) begin
				if (cand > level) begin
					level_nx = cand;
				end
				if (level_nx == cfg.level_count) begin
					max_flag_nx = 1'b1;
				end
			end
		end
	end

	// duration saturates at the field's top
	assign dur_wide = 32'(last_duration_nx);

	always_comb begin
		result.released = released;
		if (dur_wide > 32'h0000_FFFF) begin
			result.press_duration = '1;
		end else begin
			result.press_duration = dur_wide[mlpd_pkg::DURATION_WIDTH-1:0];
		end
		result.press_level = level_nx;
		result.max_reached = max_flag_nx;
		result.held = timing_nx && (last_pin_nx == cfg.active_level);
	end

endmodule

// ===== hw/rtl/multi_level_long_press_detector.sv =====
// top level of the multi-level long-press detector
//
// usage
// - item channel (item_valid, item_stall, item): each transfer is one time
//   tick carrying the sampled pin level, or a clear command
// - result channel (result_valid, result_stall, result): exactly one result
//   transfer per item, in order; released pulses on the item that ends a press
// - cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no item is in flight
// - path: an accepted item is captured in the input register, then goes
//   through the update logic into the result register
// - throughput: one item per cycle unless a result stalls; the update is one
//   compare per threshold plus the timer increment between the two registers
// - stall: while result_stall holds a waiting result, an empty input register
//   still takes one more item, then item_stall rises until the result moves
// - reset: arst_n clears timer, level, flag, duration and both valid bits;
//   registers return to active-low pressing and the default six thresholds
module multi_level_long_press_detector #(
	parameter int MAX_LEVELS = 6,
	parameter int TIME_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  mlpd_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output mlpd_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mlpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mlpd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	mlpd_pkg::cfg_t                                      cfg;
	logic [MAX_LEVELS-1:0][mlpd_pkg::CFG_DATA_WIDTH-1:0] thresholds;

	// input stage
	logic            item_valid_s1;
	mlpd_pkg::item_t item_s1;

	// press state
	logic                             last_pin_q;
	logic                             timing_q;
	logic [TIME_WIDTH-1:0]            elapsed_q;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0] level_q;
	logic [TIME_WIDTH-1:0]            last_duration_q;
	logic                             max_flag_q;

	logic                             last_pin_nx;
	logic                             timing_nx;
	logic [TIME_WIDTH-1:0]            elapsed_nx;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0] level_nx;
	logic [TIME_WIDTH-1:0]            last_duration_nx;
	logic                             max_flag_nx;
	mlpd_pkg::result_t                result_nx;

	// result register
	logic              result_valid_s2;
	mlpd_pkg::result_t result_s2;

	logic result_blocked;
	logic advance;

	mlpd_cfg #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.thresholds (thresholds)
	);

	// a waiting result that the receiver holds off blocks the input stage
	assign result_blocked = result_valid_s2 && result_stall;
	assign advance = item_valid_s1 && !result_blocked;
	assign item_stall = item_valid_s1 && result_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mlpd_step #(
		.MAX_LEVELS (MAX_LEVELS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.item             (item_s1),
		.cfg              (cfg),
		.thresholds       (thresholds),
		.last_pin         (last_pin_q),
		.timing           (timing_q),
		.elapsed          (elapsed_q),
		.level            (level_q),
		.last_duration    (last_duration_q),
		.max_flag         (max_flag_q),
		.last_pin_nx      (last_pin_nx),
		.timing_nx        (timing_nx),
		.elapsed_nx       (elapsed_nx),
		.level_nx         (level_nx),
		.last_duration_nx (last_duration_nx),
		.max_flag_nx      (max_flag_nx),
		.result           (result_nx)
	);

	// state moves only when the item's result is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pin_q <= 1'b0;
			timing_q <= 1'b0;
			elapsed_q <= '0;
			level_q <= '0;
			last_duration_q <= '0;
			max_flag_q <= 1'b0;
		end else if (advance) begin
			last_pin_q <= last_pin_nx;
			timing_q <= timing_nx;
			elapsed_q <= elapsed_nx;
			level_q <= level_nx;
			last_duration_q <= last_duration_nx;
			max_flag_q <= max_flag_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nx;
		end
	end

	assign result_valid = result_valid_s2;
	assign result = result_s2;

	// the input stage is only held while it has an item
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> item_valid_s1)
		else $error("item stall without a held item");

	// the shown held flag matches the press state behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 |-> (result_s2.held == (timing_q && (last_pin_q == cfg.active_level))))
		else $error("held flag out of step with press state");

	// a press that just ended is no longer held
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_s2 && result_s2.released) |-> !result_s2.held)
		else $error("released and held together");

	// the max flag needs a level
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_s2 && result_s2.max_reached) |-> (result_s2.press_level != '0))
		else $error("max reached with no level");

	// the level never passes the built levels
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 |-> (result_s2.press_level <= mlpd_pkg::LEVEL_WIDTH'(MAX_LEVELS)))
		else $error("press level beyond the top level");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the multi-level long-press detector
`timescale 1ns / 100ps

module tb_top;

	localparam int LEVELS = 6;
	localparam logic [mlpd_pkg::DURATION_WIDTH-1:0] TICKS_TOP = '1;
	// cycles with no transfer on any channel before the run is declared hung
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	mlpd_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	mlpd_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mlpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [mlpd_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

	multi_level_long_press_detector #(
		.MAX_LEVELS(LEVELS),
		.TIME_WIDTH(mlpd_pkg::DURATION_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns period, first rising edge at 5 ns
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// shadow copy of the registers and of the press-timing state
	// ---------------------------------------------------------------
	logic                                cfg_pressed = mlpd_pkg::ACTIVE_LEVEL_RESET;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0]    cfg_count = mlpd_pkg::LEVEL_COUNT_RESET;
	logic [mlpd_pkg::CFG_DATA_WIDTH-1:0] cfg_threshold [mlpd_pkg::THRESHOLD_SLOTS];

	logic                                prev_pin = 1'b0;
	logic                                timing_on = 1'b0;
	logic [mlpd_pkg::DURATION_WIDTH-1:0] ticks_held = '0;
	logic [mlpd_pkg::LEVEL_WIDTH-1:0]    level_now = '0;
	logic [mlpd_pkg::DURATION_WIDTH-1:0] stored_duration = '0;
	logic                                top_flag = 1'b0;

	initial begin
		for (int k = 0; k < mlpd_pkg::THRESHOLD_SLOTS; k++)
			cfg_threshold[k] = mlpd_pkg::THRESHOLD_RESET[k];
	end

	// advances the shadow state by one item and returns the report it should produce
	function automatic mlpd_pkg::result_t next_press_report(mlpd_pkg::item_t it);
		mlpd_pkg::result_t r;
		logic pin_edge;
		logic finished;
		int n;
		int cand;
		r = '0;
		finished = 1'b0;
		if (it.mode == mlpd_pkg::MODE_CLEAR) begin
			// clear drops everything except the last pin sample
			stored_duration = '0;
			level_now = '0;
			top_flag = 1'b0;
			timing_on = 1'b0;
			ticks_held = '0;
		end else begin
			pin_edge = (it.pin_level != prev_pin);
			// the timer runs on every tick except the one that restarts it
			if (timing_on && !(pin_edge && it.pin_level == cfg_pressed)) begin
				if (ticks_held != TICKS_TOP)
					ticks_held = ticks_held + 1'b1;
			end
			if (pin_edge) begin
				prev_pin = it.pin_level;
				if (it.pin_level == cfg_pressed) begin
					timing_on = 1'b1;
					ticks_held = '0;
				end else if (timing_on) begin
					stored_duration = ticks_held;
					timing_on = 1'b0;
					r.released = 1'b1;
					finished = 1'b1;
				end
			end
			if (!finished && prev_pin == cfg_pressed && timing_on) begin
				// out-of-range counts clamp to 1..LEVELS
				n = int'(cfg_count);
				if (n < 1)
					n = 1;
				if (n > LEVELS)
					n = LEVELS;
				// highest slot reached wins, even when slots are not ascending
				cand = 0;
				for (int i = 1; i <= n; i++) begin
					if (ticks_held >= cfg_threshold[i-1])
						cand = i;
				end
				if (cand > int'(level_now))
					level_now = mlpd_pkg::LEVEL_WIDTH'(cand);
				if (int'(level_now) == n)
					top_flag = 1'b1;
			end
		end
		r.press_duration = stored_duration;
		r.press_level = level_now;
		r.max_reached = top_flag;
		r.held = timing_on && (prev_pin == cfg_pressed);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// driver: item channel, fed from the pending queue
	// ---------------------------------------------------------------
	mlpd_pkg::item_t ticks_to_send [$];
	int unsigned     items_issued = 0;
	int unsigned     items_taken = 0;
	logic            item_moved = 1'b0;
	int unsigned     burst_left = 0;
	int unsigned     gap_left = 0;

	// payload is held while stalled; a new item goes out only when idle or after a transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_moved) begin
			if (gap_left != 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (ticks_to_send.size() != 0) begin
				item <= ticks_to_send.pop_front();
				item_valid <= 1'b1;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 48);
				burst_left--;
				// a third of the bursts run straight into the next one
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver stall: a rotating 8-bit pattern, reloaded per segment
	// ---------------------------------------------------------------
	logic [7:0]  stall_pattern = '0;
	int unsigned stall_span = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_span == 0) begin
			stall_span = $urandom_range(16, 160);
			case ($urandom_range(0, 3))
				0: begin
					// no back-pressure at all for this segment
					stall_pattern <= '0;
				end
				1: begin
					stall_pattern <= 8'($urandom);
				end
				2: begin
					stall_pattern <= 8'($urandom) & 8'($urandom);
				end
				default: begin
					// dense, but at least one open slot per rotation
					stall_pattern <= (8'($urandom) | 8'($urandom)) &
						~(8'd1 << $urandom_range(0, 7));
				end
			endcase
			result_stall <= 1'b0;
		end else begin
			stall_span--;
			result_stall <= stall_pattern[0];
			stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
		end
	end

	// ---------------------------------------------------------------
	// monitor: predicts on item transfers, checks result transfers
	// ---------------------------------------------------------------
	mlpd_pkg::result_t press_reports_due [$];
	int unsigned       mismatches = 0;
	int unsigned       results_seen = 0;
	int unsigned       releases_seen = 0;
	int unsigned       top_releases = 0;
	int unsigned       settings_used = 1;
	int unsigned       quiet_cycles = 0;

	task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		mlpd_pkg::result_t due;
		if (arst_n) begin
			item_moved <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				press_reports_due.push_back(next_press_report(item));
				items_taken++;
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (press_reports_due.size() == 0) begin
					$error("result transfer with no press report due");
					mismatches++;
				end else begin
					due = press_reports_due.pop_front();
					check_field("released", 16'(due.released), 16'(result.released));
					check_field("press_duration", due.press_duration, result.press_duration);
					check_field("press_level", 16'(due.press_level), 16'(result.press_level));
					check_field("max_reached", 16'(due.max_reached), 16'(result.max_reached));
					check_field("held", 16'(due.held), 16'(result.held));
					if (due.released) begin
						releases_seen++;
						if (due.max_reached)
							top_releases++;
					end
				end
			end
			// watchdog: any transfer on any channel counts as progress
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_run(logic mode, logic pin, int unsigned count);
		mlpd_pkg::item_t it;
		it.mode = mode;
		it.pin_level = pin;
		repeat (count) begin
			ticks_to_send.push_back(it);
			items_issued++;
		end
	endtask

	// one register write; the shadow copy follows at the write edge
	task automatic cfg_write(logic [mlpd_pkg::CFG_INDEX_WIDTH-1:0] idx,
		logic [mlpd_pkg::CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			mlpd_pkg::CFG_ACTIVE_LEVEL: cfg_pressed = data[0];
			mlpd_pkg::CFG_LEVEL_COUNT: cfg_count = data[mlpd_pkg::LEVEL_WIDTH-1:0];
			default: cfg_threshold[idx - mlpd_pkg::CFG_THRESHOLD_BASE] = data;
		endcase
	endtask

	task automatic close_cfg_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// sender holds off until every item is through and every report is back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_taken != items_issued || press_reports_due.size() != 0);
		// two-stage pipe, plus margin
		repeat (4) @(negedge clk);
	endtask

	task automatic pick_random_settings();
		logic [mlpd_pkg::CFG_DATA_WIDTH-1:0] ramp;
		logic [mlpd_pkg::CFG_DATA_WIDTH-1:0] value;
		int unsigned style;
		int unsigned k;
		cfg_write(mlpd_pkg::CFG_ACTIVE_LEVEL,
			mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 1)));
		// includes 0 and 7, which the block clamps
		cfg_write(mlpd_pkg::CFG_LEVEL_COUNT, mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 7)));
		style = $urandom_range(0, 2);
		ramp = mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 3));
		for (k = 0; k < mlpd_pkg::THRESHOLD_SLOTS; k++) begin
			ramp = ramp + mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 6));
			case (style)
				0: value = ramp;
				1: value = mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 30));
				default: begin
					case ($urandom_range(0, 3))
						0: value = '0;
						1: value = '1;
						2: value = mlpd_pkg::CFG_DATA_WIDTH'($urandom);
						default: value = mlpd_pkg::CFG_DATA_WIDTH'($urandom_range(0, 30));
					endcase
				end
			endcase
			// leave some slots as they were
			if ($urandom_range(0, 3) != 0)
				cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + mlpd_pkg::CFG_INDEX_WIDTH'(k),
					value);
		end
		close_cfg_writes();
	endtask

	// mostly clean press/release sequences, some clears mid-hold, some noise
	task automatic queue_random_traffic(int unsigned budget);
		int unsigned first;
		int unsigned pick;
		int unsigned hold;
		logic rest_pin;
		first = items_issued;
		rest_pin = ~cfg_pressed;
		while (items_issued - first < budget) begin
			pick = $urandom_range(0, 99);
			hold = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150) :
				$urandom_range(0, 24);
			if (pick < 65) begin
				queue_run(mlpd_pkg::MODE_TICK, rest_pin, $urandom_range(1, 3));
				queue_run(mlpd_pkg::MODE_TICK, cfg_pressed, hold + 1);
				queue_run(mlpd_pkg::MODE_TICK, rest_pin, 1);
				if ($urandom_range(0, 3) == 0)
					queue_run(mlpd_pkg::MODE_CLEAR, 1'($urandom_range(0, 1)), 1);
			end else if (pick < 80) begin
				// clear while held: the rest of the hold goes untimed
				queue_run(mlpd_pkg::MODE_TICK, rest_pin, 1);
				queue_run(mlpd_pkg::MODE_TICK, cfg_pressed, hold / 2 + 1);
				queue_run(mlpd_pkg::MODE_CLEAR, 1'($urandom_range(0, 1)), 1);
				queue_run(mlpd_pkg::MODE_TICK, cfg_pressed, $urandom_range(1, 5));
				queue_run(mlpd_pkg::MODE_TICK, rest_pin, 1);
			end else begin
				repeat ($urandom_range(1, 6))
					queue_run(($urandom_range(0, 7) == 0) ? mlpd_pkg::MODE_CLEAR :
						mlpd_pkg::MODE_TICK, 1'($urandom_range(0, 1)), 1);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, active low; pin starts low, at the pressed level but untimed
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);	// leaving pressed level with no timing
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 2);	// press, one tick held
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);	// release, duration 2
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);	// press again, level kept
		queue_run(mlpd_pkg::MODE_CLEAR, 1'b0, 1);	// clear while held
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);	// still held, not timed after clear
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);
		wait_drained();

		// active high, three levels, zero first threshold, unused slots set too
		cfg_write(mlpd_pkg::CFG_ACTIVE_LEVEL, 16'd1);
		cfg_write(mlpd_pkg::CFG_LEVEL_COUNT, 16'd3);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd0, 16'd0);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd1, 16'd2);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd2, 16'd4);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd3, 16'd1);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd4, 16'd1);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd5, 16'hFFFF);
		close_cfg_writes();
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 5);	// level 1 on the press tick, max on the last tick
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);	// release, duration 5
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);	// new press without clear
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);	// release, duration 1
		queue_run(mlpd_pkg::MODE_CLEAR, 1'b1, 1);
		wait_drained();

		// level count of zero behaves as one
		cfg_write(mlpd_pkg::CFG_ACTIVE_LEVEL, 16'd0);
		cfg_write(mlpd_pkg::CFG_LEVEL_COUNT, 16'd0);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd0, 16'd2);
		close_cfg_writes();
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 3);
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 1);
		wait_drained();

		// count of seven behaves as six; thresholds out of order
		cfg_write(mlpd_pkg::CFG_ACTIVE_LEVEL, 16'd1);
		cfg_write(mlpd_pkg::CFG_LEVEL_COUNT, 16'd7);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd0, 16'd3);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd1, 16'd1);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd2, 16'd5);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd3, 16'd2);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd4, 16'd6);
		close_cfg_writes();
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 7);
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);
		wait_drained();

		// one long hold across the lower thresholds, the upper ones out of reach
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd0, 16'd10);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd1, 16'd100);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd2, 16'd1000);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd3, 16'd10000);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd4, 16'd60000);
		cfg_write(mlpd_pkg::CFG_THRESHOLD_BASE + 3'd5, 16'hFFFF);
		close_cfg_writes();
		queue_run(mlpd_pkg::MODE_CLEAR, 1'b0, 1);
		queue_run(mlpd_pkg::MODE_TICK, 1'b1, 130);	// level 2 once 100 ticks are held
		queue_run(mlpd_pkg::MODE_TICK, 1'b0, 1);	// release, duration 130
		queue_run(mlpd_pkg::MODE_CLEAR, 1'b1, 1);
		wait_drained();

		// random settings, each followed by a full drain
		repeat (8) begin
			pick_random_settings();
			queue_random_traffic(210);
			wait_drained();
		end

		$display("ran %0d items under %0d register settings: %0d results checked,",
			items_taken, settings_used, results_seen);
		$display("%0d timed releases, %0d of them at the top level", releases_seen,
			top_releases);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
